FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Sizes of the entry store, command and status codes, memory request bundle.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths at the ports
  localparam int POS_W  = 7;
  localparam int OUT_W  = 7;

  // Width that holds both a position and a count, plus one for count + 1
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_DELETE    = 2'd1,
    CMD_SEARCH    = 2'd2,
    CMD_OVERWRITE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // One write port and one read port per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: design/ple_mem.sv
// ----------------------------------------------------------------------------
// ple_mem: entry store of the positional list engine
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ple_mem
  import ple_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write and read the store
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list with insert, delete, search, overwrite
// Sequencer over one entry store and one shared step/compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_cmd, in_item_value and in_place; the transfer takes
//   place at a rising edge where busy is low. Each request yields exactly one
//   result on out_status, out_found_place and out_entry_count, shown for one
//   cycle with out_valid high. The receiver cannot stall the result.
// Steps (count = stored entries, pos = requested position):
//   overwrite and every rejected request: answered from idle; busy stays low,
//     so a request can follow in the next cycle.
//   insert: entries pos to count each move up one slot, the last first, then
//     the new value is written at pos; appending at count + 1 moves nothing.
//   delete: entries pos + 1 to count each move down one slot, the first first;
//     deleting at pos = count moves nothing.
//   search: entries are read in order from position 1 up to the first match,
//     or to the end when nothing matches; an empty list needs no read.
//   The store moves or reads one entry per cycle through its single read
//   and write ports.
// Reset: synchronous, active low; the list becomes empty at once. Entry
//   contents are not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine
  import ple_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic [DATA_W-1:0] in_item_value,
  input  logic [POS_W-1:0]  in_place,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [OUT_W-1:0]  out_found_place,
  output logic [OUT_W-1:0]  out_entry_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_SCAN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0] rd_prev_r, rd_prev_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [ADDR_W-1:0] ins_addr_r, ins_addr_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic              pend_r, pend_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [OUT_W-1:0]  out_found_r, out_found_nxt;
  logic [OUT_W-1:0]  out_count_r, out_count_nxt;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_data;

  logic [CMP_W-1:0]  pos_x, cnt_x;
  logic              pos_zero, ins_ok, pos_ok, full;
  logic              step_dn;
  logic [ADDR_W-1:0] step_idx;
  logic              hit;
  logic [ADDR_W-1:0] pos_idx;

  ple_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Check the requested position against the current count
  assign pos_x    = CMP_W'(in_place);
  assign cnt_x    = CMP_W'(count_r);
  assign pos_zero = (pos_x == '0);
  assign ins_ok   = !pos_zero && (pos_x <= cnt_x + CMP_W'(1));
  assign pos_ok   = !pos_zero && (pos_x <= cnt_x);
  assign full     = (cnt_x == CMP_W'(DEPTH));
  assign pos_idx  = ADDR_W'(in_place) - ADDR_W'(1);

  // Shared unit: walk the read index and compare the returned entry
  assign step_dn  = (cmd_r == CMD_INSERT);
  assign step_idx = rd_idx_r + (step_dn ? {ADDR_W{1'b1}} : ADDR_W'(1));
  assign hit      = pend_r && (rd_data == val_r);

  // Sequence the requests
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    rd_idx_nxt     = rd_idx_r;
    rd_prev_nxt    = rd_prev_r;
    wr_addr_nxt    = wr_addr_r;
    ins_addr_nxt   = ins_addr_r;
    remain_nxt     = remain_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    mem_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt       = cmd_t'(in_cmd);
          val_nxt       = in_item_value;
          pend_nxt      = 1'b0;
          out_found_nxt = '0;
          case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              if (!ins_ok) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end else if (full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end else begin
                rd_idx_nxt   = ADDR_W'(count_r) - ADDR_W'(1);
                wr_addr_nxt  = ADDR_W'(count_r);
                remain_nxt   = CNT_W'(cnt_x - pos_x + CMP_W'(1));
                ins_addr_nxt = pos_idx;
                state_nxt    = S_SHIFT;
              end
            end
            CMD_DELETE: begin
              if (!pos_ok) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end else begin
                rd_idx_nxt  = ADDR_W'(in_place);
                wr_addr_nxt = pos_idx;
                remain_nxt  = CNT_W'(cnt_x - pos_x);
                state_nxt   = S_SHIFT;
              end
            end
            CMD_SEARCH: begin
              rd_idx_nxt = '0;
              remain_nxt = count_r;
              state_nxt  = S_SCAN;
            end
            CMD_OVERWRITE: begin
              out_valid_nxt = 1'b1;
              if (!pos_ok) begin
                out_status_nxt = ST_RANGE;
              end else begin
                out_status_nxt = ST_DONE;
                mem_req.we     = 1'b1;
                mem_req.waddr  = pos_idx;
                mem_req.wdata  = in_item_value;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_RANGE;
            end
          endcase
        end
      end

      // Move one entry per cycle: write the last read, issue the next
      S_SHIFT: begin
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_addr_r;
          mem_req.wdata = rd_data;
          wr_addr_nxt   = rd_prev_r;
        end
        if (remain_r != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_idx_r;
          rd_prev_nxt   = rd_idx_r;
          rd_idx_nxt    = step_idx;
          remain_nxt    = remain_r - CNT_W'(1);
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (cmd_r == CMD_INSERT) begin
              state_nxt = S_PLACE;
            end else begin
              count_nxt      = count_r - CNT_W'(1);
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_DONE;
              state_nxt      = S_IDLE;
            end
          end
        end
      end

      // Drop the new value into the opened slot
      S_PLACE: begin
        mem_req.we     = 1'b1;
        mem_req.waddr  = ins_addr_r;
        mem_req.wdata  = val_r;
        count_nxt      = count_r + CNT_W'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        state_nxt      = S_IDLE;
      end

      // Read entries in order and stop at the first match
      S_SCAN: begin
        if (hit) begin
          pend_nxt       = 1'b0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_found_nxt  = OUT_W'(CNT_W'(rd_prev_r) + CNT_W'(1));
          state_nxt      = S_IDLE;
        end else if (remain_r != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_idx_r;
          rd_prev_nxt   = rd_idx_r;
          rd_idx_nxt    = step_idx;
          remain_nxt    = remain_r - CNT_W'(1);
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOTFOUND;
            state_nxt      = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_count_nxt = OUT_W'(count_nxt);
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rd_prev_r    <= rd_prev_nxt;
    wr_addr_r    <= wr_addr_nxt;
    ins_addr_r   <= ins_addr_nxt;
    remain_r     <= remain_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_place = out_found_r;
  assign out_entry_count = out_count_r;

  // The count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("entry count beyond store depth");

  // A result appears only once the sequencer is back at rest
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result while sequencer busy");

  // The count changes only together with a result
  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> out_valid_r)
    else $error("count changed without a result");

  // A shift never writes the slot it reads in the same cycle
  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("read and write at the same entry");

  // A result follows a transfer or the end of a busy phase
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(busy) || $past(start)))
    else $error("result without a request");

endmodule

FILE: verif/positional_list_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb: self-checking bench for the positional list engine
// Drives insert, delete, search and overwrite requests through the start/busy
// port. A shadow list predicts status, match position and entry count for each
// transfer, and the monitor compares every result strobe against it in order.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int RANDOM_ITEMS   = 550;
  localparam int MAX_GAP        = 40;
  localparam int POOL_SIZE      = 24;
  localparam int TAIL_CYCLES    = DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    cmd_t              cmd;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  place;
    int                gap;
    bit                drain;
  } list_request_t;

  typedef struct packed {
    status_t          status;
    logic [OUT_W-1:0] found_place;
    logic [OUT_W-1:0] entry_count;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd = CMD_SEARCH;
  logic [DATA_W-1:0] in_item_value = '0;
  logic [POS_W-1:0]  in_place = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [OUT_W-1:0]  out_found_place;
  logic [OUT_W-1:0]  out_entry_count;

  // Stimulus and prediction state
  list_request_t     request_q[$];
  list_result_t      expected_q[$];
  logic [DATA_W-1:0] list_mem [DEPTH];
  int                list_len;
  int                gen_len;
  logic [DATA_W-1:0] value_pool[$];
  int                idle_pct;
  int                idle_cycles = 0;
  int                mismatch_count = 0;
  int                gap_cnt = 0;
  bit                gap_loaded = 1'b0;

  logic [DATA_W-1:0] corner_vals [4] = '{32'h0000_0000, 32'hffff_ffff,
                                         32'h8000_0000, 32'h7fff_ffff};

  positional_list_engine u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_item_value   (in_item_value),
    .in_place        (in_place),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_place (out_found_place),
    .out_entry_count (out_entry_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Apply one request to the shadow list and return the result it must give
  function automatic list_result_t apply_list_request(input cmd_t cmd,
                                                      input logic [DATA_W-1:0] value,
                                                      input logic [POS_W-1:0] place);
    list_result_t res;
    int           pos;
    int           i;
    bit           hit;
    res.status      = ST_DONE;
    res.found_place = '0;
    pos             = int'(place);
    hit             = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (pos < 1 || pos > list_len + 1) begin
          res.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i >= pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos-1] = value;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        res.status = ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (!hit && list_mem[i] == value) begin
            hit             = 1'b1;
            res.status      = ST_DONE;
            res.found_place = OUT_W'(i + 1);
          end
        end
      end
      default: begin
        if (pos < 1 || pos > list_len) res.status = ST_RANGE;
        else list_mem[pos-1] = value;
      end
    endcase
    res.entry_count = OUT_W'(list_len);
    return res;
  endfunction

  // Queue one request with a sender gap drawn from the current idle rate,
  // and track the list length and recent values to steer later requests
  function automatic void add_request(input cmd_t cmd, input logic [DATA_W-1:0] value,
                                      input logic [POS_W-1:0] place, input bit drain);
    list_request_t req;
    int            gap;
    int            p;
    bit            keep;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    req.cmd   = cmd;
    req.value = value;
    req.place = place;
    req.gap   = gap;
    req.drain = drain;
    request_q.push_back(req);
    p    = int'(place);
    keep = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (p >= 1 && p <= gen_len + 1 && gen_len < DEPTH) begin
          gen_len++;
          keep = 1'b1;
        end
      end
      CMD_DELETE:    if (p >= 1 && p <= gen_len) gen_len--;
      CMD_OVERWRITE: keep = (p >= 1 && p <= gen_len);
      default: ;
    endcase
    if (keep) begin
      value_pool.push_back(value);
      if (value_pool.size() > POOL_SIZE) void'(value_pool.pop_front());
    end
  endfunction

  // Driver: predict on each transfer, then present the next request or idle
  always @(posedge clk) begin
    list_request_t req;
    bit            launch;
    if (!rst_n) begin
      start      <= 1'b0;
      list_len   = 0;
      gap_loaded = 1'b0;
    end else begin
      launch = start && !busy;
      if (launch) begin
        expected_q.push_back(apply_list_request(cmd_t'(in_cmd), in_item_value, in_place));
      end
      if (!start || launch) begin
        if (request_q.size() == 0) begin
          start <= 1'b0;
        end else begin
          if (!gap_loaded) begin
            gap_cnt    = request_q[0].gap;
            gap_loaded = 1'b1;
          end
          if (gap_cnt > 0) begin
            gap_cnt--;
            start <= 1'b0;
          end else if (request_q[0].drain && expected_q.size() != 0) begin
            // hold off until every outstanding result has come back
            start <= 1'b0;
          end else begin
            req           = request_q.pop_front();
            gap_loaded    = 1'b0;
            start         <= 1'b1;
            in_cmd        <= req.cmd;
            in_item_value <= req.value;
            in_place      <= req.place;
          end
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        $display("%0t: unexpected result status=%0d found_place=%0d entry_count=%0d",
                 $time, out_status, out_found_place, out_entry_count);
      end else begin
        want = expected_q.pop_front();
        if (want.status != status_t'(out_status) || want.found_place != out_found_place ||
            want.entry_count != out_entry_count) begin
          mismatch_count <= mismatch_count + 1;
          $display("%0t: mismatch exp st=%0d fp=%0d cnt=%0d act st=%0d fp=%0d cnt=%0d",
                   $time, want.status, want.found_place, want.entry_count,
                   out_status, out_found_place, out_entry_count);
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int                n;
    int                r;
    int                hi;
    cmd_t              cmd;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  place;
    bit                fill_mode;

    gen_len  = 0;
    idle_pct = 19;

    // Directed: empty store, bad positions, extremes, duplicates, edges
    add_request(CMD_SEARCH,    32'h0000_0000, 7'd0,   1'b0);
    add_request(CMD_DELETE,    32'h1234_5678, 7'd1,   1'b0);
    add_request(CMD_OVERWRITE, 32'hdead_beef, 7'd1,   1'b0);
    add_request(CMD_INSERT,    32'h0000_0001, 7'd0,   1'b0);
    add_request(CMD_INSERT,    32'h0000_0002, 7'd2,   1'b0);
    add_request(CMD_INSERT,    32'h7fff_ffff, 7'd1,   1'b0);
    add_request(CMD_INSERT,    32'h8000_0000, 7'd1,   1'b0);
    add_request(CMD_INSERT,    32'hffff_ffff, 7'd3,   1'b0);
    add_request(CMD_INSERT,    32'h0000_0000, 7'd2,   1'b1);
    add_request(CMD_INSERT,    32'h0000_0005, 7'd127, 1'b0);
    add_request(CMD_SEARCH,    32'hffff_ffff, 7'd127, 1'b0);
    add_request(CMD_SEARCH,    32'h8000_0000, 7'd0,   1'b0);
    add_request(CMD_OVERWRITE, 32'h0000_0000, 7'd4,   1'b0);
    add_request(CMD_SEARCH,    32'h0000_0000, 7'd55,  1'b0);
    add_request(CMD_OVERWRITE, 32'h5555_5555, 7'd5,   1'b0);
    add_request(CMD_OVERWRITE, 32'haaaa_aaaa, 7'd0,   1'b0);
    add_request(CMD_DELETE,    32'h0000_0000, 7'd5,   1'b0);
    add_request(CMD_DELETE,    32'h0000_0000, 7'd0,   1'b0);
    add_request(CMD_DELETE,    32'hffff_ffff, 7'd127, 1'b0);
    add_request(CMD_DELETE,    32'h0000_0000, 7'd1,   1'b0);
    add_request(CMD_DELETE,    32'h0000_0000, 7'd3,   1'b0);
    add_request(CMD_SEARCH,    32'h1234_5678, 7'd42,  1'b0);
    add_request(CMD_OVERWRITE, 32'h5555_5555, 7'd1,   1'b0);
    add_request(CMD_SEARCH,    32'h5555_5555, 7'd85,  1'b0);

    // Random: alternate fill-heavy and drain-heavy stretches so the list
    // runs between empty and full; the idle rate changes over three phases
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) idle_pct = 72;
      else if (n == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
      fill_mode = ((n / 160) % 2) == 0;
      r = $urandom_range(99);
      if (fill_mode)
        cmd = (r < 70) ? CMD_INSERT : (r < 80) ? CMD_DELETE :
              (r < 90) ? CMD_SEARCH : CMD_OVERWRITE;
      else
        cmd = (r < 15) ? CMD_INSERT : (r < 70) ? CMD_DELETE :
              (r < 85) ? CMD_SEARCH : CMD_OVERWRITE;

      // favor stored values for searches so hits and duplicates occur
      r = $urandom_range(99);
      if (value_pool.size() != 0 && r < ((cmd == CMD_SEARCH) ? 60 : 25))
        value = value_pool[$urandom_range(value_pool.size() - 1)];
      else if (r < ((cmd == CMD_SEARCH) ? 70 : 40))
        value = corner_vals[$urandom_range(3)];
      else
        value = $urandom;

      // mostly legal positions, some at the edges, some anywhere
      r  = $urandom_range(99);
      hi = (cmd == CMD_INSERT) ? gen_len + 1 : gen_len;
      if (cmd == CMD_SEARCH || r >= 92)
        place = POS_W'($urandom_range(127));
      else if (r < 82 && hi > 0)
        place = POS_W'($urandom_range(hi, 1));
      else
        place = ($urandom_range(1) == 0) ? '0 : POS_W'(hi + 1);

      add_request(cmd, value, place, (n % 100 == 0) || (n == RANDOM_ITEMS / 3));
    end

    // Release reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (!(request_q.size() == 0 && !start && expected_q.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(negedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, expected_q.size());
      $display("positional_list_engine_tb: FAIL");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
        $display("positional_list_engine_tb: PASS");
      end else begin
        $display("positional_list_engine_tb: FAIL");
      end
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ple_pkg.sv
design/ple_mem.sv
design/positional_list_engine.sv
verif/positional_list_engine_tb.sv
